FILE: hdl/dru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the dirty region frame updater.
package dru_pkg;

    localparam int DEF_PANEL_WIDTH  = 135;
    localparam int DEF_PANEL_HEIGHT = 240;
    localparam int DEF_CHUNK_PIXELS = 128;

    localparam int COORD_W = 8;

    localparam logic REG_ROTATION = 1'b0;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_START = 2'd2,
        MODE_PULL  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_IDLE   = 2'd0,
        KIND_WINDOW = 2'd1,
        KIND_PIXEL  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] win_x_start;
        logic [COORD_W-1:0] win_x_end;
        logic [COORD_W-1:0] win_y_start;
        logic [COORD_W-1:0] win_y_end;
        logic [15:0]        pixel_value;
        logic               chunk_end;
    } res_t;

    typedef struct packed {
        logic               clear;
        logic               valid;
        logic [COORD_W-1:0] col;
    } span_ctrl_t;

    typedef struct packed {
        logic               any;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } span_stat_t;

endpackage

FILE: hdl/dru_req_if.sv
`timescale 1ns / 1ps
// Request channel: pixel writes, fills, transfer starts and pulls.
interface dru_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] pixel_color;

    modport source (output valid, mode, pos_x, pos_y, pixel_color, input ready);
    modport sink (input valid, mode, pos_x, pos_y, pixel_color, output ready);
endinterface

FILE: hdl/dru_res_if.sv
`timescale 1ns / 1ps
// Result channel: idle, window or pixel results.
interface dru_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  win_x_start;
    logic [7:0]  win_x_end;
    logic [7:0]  win_y_start;
    logic [7:0]  win_y_end;
    logic [15:0] pixel_value;
    logic        chunk_end;

    modport source (output valid, kind, win_x_start, win_x_end, win_y_start, win_y_end,
                    pixel_value, chunk_end, input ready);
    modport sink (input valid, kind, win_x_start, win_x_end, win_y_start, win_y_end,
                  pixel_value, chunk_end, output ready);
endinterface

FILE: hdl/dru_ram.sv
`timescale 1ns / 1ps
// Generic single write, single read RAM with registered read data.
module dru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/dru_span.sv
`timescale 1ns / 1ps
// Row span unit: first and last column where frame and shadow differ.
module dru_span
    import dru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  span_ctrl_t  ctrl,
    input  logic [15:0] frame_data,
    input  logic [15:0] shadow_data,
    output span_stat_t  stat
);

    logic               any_reg, any_next;
    logic [COORD_W-1:0] lo_reg, lo_next;
    logic [COORD_W-1:0] hi_reg, hi_next;

    always_comb
    begin
        any_next = any_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (ctrl.clear)
        begin
            any_next = 1'b0;
        end
        else if (ctrl.valid && (frame_data != shadow_data))
        begin
            if (!any_reg)
            begin
                lo_next = ctrl.col;
            end
            hi_next  = ctrl.col;
            any_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end
        else
        begin
            any_reg <= any_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
        end
    end

    assign stat = '{any: any_reg, lo: lo_reg, hi: hi_reg};

endmodule

FILE: hdl/dirty_region_frame_updater.sv
`timescale 1ns / 1ps
// Dirty region frame updater: frame and shadow stores, row flags, region sequencer.
//
//  channel | direction | handshake          | carries
//  req     | in        | valid/ready        | mode, pos_x, pos_y, pixel_color
//  res     | out       | valid/ready        | kind, window bounds, pixel_value, chunk_end
//  apb     | in        | psel/penable/pready| rotation register at address 0
//
// A region search probes each row's touched flag and compares touched rows column
// by column (shared compare unit over one read port of each store).
// After reset a clearing pass zeroes both stores and the row flags;
// req.ready stays low.
// A result waits in an output register; the block stalls only until it is taken.
module dirty_region_frame_updater
    import dru_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int CHUNK_PIXELS = DEF_CHUNK_PIXELS
) (
    input  logic        clk,
    input  logic        rst_n,
    dru_req_if.sink     req,
    dru_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N       = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int ADDR_W  = $clog2(N);
    localparam int ROW_W   = $clog2(PANEL_HEIGHT);
    localparam int PROBE_W = $clog2(PANEL_HEIGHT + 1);
    localparam int CHUNK_W = $clog2(CHUNK_PIXELS + 1);

    localparam logic [ADDR_W-1:0]  W_A      = ADDR_W'(PANEL_WIDTH);
    localparam logic [ADDR_W-1:0]  H_A      = ADDR_W'(PANEL_HEIGHT);
    localparam logic [ADDR_W-1:0]  LAST_A   = ADDR_W'(N - 1);
    localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [PROBE_W-1:0] H_P      = PROBE_W'(PANEL_HEIGHT);
    localparam logic [CHUNK_W-1:0] CHUNK_C  = CHUNK_W'(CHUNK_PIXELS);
    localparam logic signed [9:0]  W_S      = 10'(PANEL_WIDTH);
    localparam logic signed [9:0]  H_S      = 10'(PANEL_HEIGHT);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_WRITE  = 9'b000000100,
        S_FILL   = 9'b000001000,
        S_SEEK   = 9'b000010000,
        S_COLS   = 9'b000100000,
        S_DECIDE = 9'b001000000,
        S_PIXEL  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          rotation_reg, rotation_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ROW_W-1:0]    wrow_reg, wrow_next;
    logic                wok_reg, wok_next;
    logic [15:0]         color_reg, color_next;
    logic [PROBE_W-1:0]  scan_row_reg, scan_row_next;
    logic [PROBE_W-1:0]  probe_reg, probe_next;
    logic                run_reg, run_next;
    logic                active_reg, active_next;
    logic                rescan_reg, rescan_next;
    logic                region_reg, region_next;
    logic                wsent_reg, wsent_next;
    logic [COORD_W-1:0]  x0_reg, x0_next;
    logic [COORD_W-1:0]  x1_reg, x1_next;
    logic [COORD_W-1:0]  y0_reg, y0_next;
    logic [COORD_W-1:0]  y1_reg, y1_next;
    logic [COORD_W-1:0]  cx_reg, cx_next;
    logic [COORD_W-1:0]  cy_reg, cy_next;
    logic [CHUNK_W-1:0]  chunk_reg, chunk_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic                issued_reg, issued_next;
    logic                cmp_v_reg, cmp_v_next;
    logic [COORD_W-1:0]  cmp_col_reg, cmp_col_next;
    res_t                stage_reg, stage_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                rd_en, f_we, s_we;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic [15:0]         f_wdata, s_wdata, f_rdata, s_rdata;
    logic                t_we, t_re, t_wdata, t_rdata;
    logic [ROW_W-1:0]    t_waddr, t_raddr;
    span_ctrl_t          span_ctrl;
    span_stat_t          span_stat;

    logic signed [9:0]   xs, ys, nx, ny;
    logic                in_rng;
    logic [ADDR_W-1:0]   map_addr, cur_addr, row_addr;
    logic [CHUNK_W-1:0]  chunk_inc;
    logic                last_px, load_out;
    res_t                win_res;

    dru_ram #(.WIDTH(16), .DEPTH(N)) u_frame (
        .clk(clk), .we(f_we), .waddr(wr_addr), .wdata(f_wdata),
        .re(rd_en), .raddr(rd_addr), .rdata(f_rdata)
    );

    dru_ram #(.WIDTH(16), .DEPTH(N)) u_shadow (
        .clk(clk), .we(s_we), .waddr(wr_addr), .wdata(s_wdata),
        .re(rd_en), .raddr(rd_addr), .rdata(s_rdata)
    );

    // touched flag per row, read from the next probe row so the flag is ready when the probe reaches it
    dru_ram #(.WIDTH(1), .DEPTH(PANEL_HEIGHT)) u_touched (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
    );

    dru_span u_span (
        .clk(clk), .rst_n(rst_n), .ctrl(span_ctrl),
        .frame_data(f_rdata), .shadow_data(s_rdata), .stat(span_stat)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROTATION) ? {30'd0, rotation_reg} : 32'd0;

    always_comb
    begin
        rotation_next = rotation_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_ROTATION))
        begin
            rotation_next = pwdata[1:0];
        end
    end

    // logical to native mapping
    always_comb
    begin
        xs = $signed({2'b00, req.pos_x});
        ys = $signed({2'b00, req.pos_y});
        unique case (rotation_reg)
            2'd1:
            begin
                nx = W_S - 10'sd1 - ys;
                ny = xs;
            end
            2'd2:
            begin
                nx = W_S - 10'sd1 - xs;
                ny = H_S - 10'sd1 - ys;
            end
            2'd3:
            begin
                nx = ys;
                ny = H_S - 10'sd1 - xs;
            end
            default:
            begin
                nx = xs;
                ny = ys;
            end
        endcase
        in_rng = (nx >= 10'sd0) && (nx < W_S) && (ny >= 10'sd0) && (ny < H_S);
    end

    assign map_addr  = ADDR_W'(ny[7:0]) * W_A + ADDR_W'(nx[7:0]);
    assign cur_addr  = ADDR_W'(cy_reg) * W_A + ADDR_W'(cx_reg);
    assign row_addr  = ADDR_W'(probe_reg[ROW_W-1:0]) * W_A + ADDR_W'(col_reg);
    assign chunk_inc = chunk_reg + CHUNK_W'(1);
    assign last_px   = (cx_reg == x1_reg) && (cy_reg == y1_reg);
    assign load_out  = (state_reg == S_EMIT) && (!out_valid_reg || res.ready);
    assign win_res   = '{kind: KIND_WINDOW, win_x_start: x0_reg, win_x_end: x1_reg,
                         win_y_start: y0_reg, win_y_end: y1_reg,
                         pixel_value: 16'd0, chunk_end: 1'b0};

    assign t_re    = (probe_next < H_P);
    assign t_raddr = probe_next[ROW_W-1:0];

    assign req.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        idx_next      = idx_reg;
        wrow_next     = wrow_reg;
        wok_next      = wok_reg;
        color_next    = color_reg;
        scan_row_next = scan_row_reg;
        probe_next    = probe_reg;
        run_next      = run_reg;
        active_next   = active_reg;
        rescan_next   = rescan_reg;
        region_next   = region_reg;
        wsent_next    = wsent_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        chunk_next    = chunk_reg;
        col_next      = col_reg;
        issued_next   = issued_reg;
        cmp_v_next    = 1'b0;
        cmp_col_next  = cmp_col_reg;
        stage_next    = stage_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_addr;
        f_we          = 1'b0;
        s_we          = 1'b0;
        wr_addr       = sweep_reg;
        f_wdata       = color_reg;
        s_wdata       = f_rdata;
        t_we          = 1'b0;
        t_waddr       = sweep_reg[ROW_W-1:0];
        t_wdata       = 1'b0;
        span_ctrl     = '{clear: 1'b0, valid: cmp_v_reg, col: cmp_col_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                f_we    = 1'b1;
                s_we    = 1'b1;
                f_wdata = 16'd0;
                s_wdata = 16'd0;
                t_we    = (sweep_reg < H_A);
                if (sweep_reg == LAST_A)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (mode_t'(req.mode))
                        MODE_WRITE:
                        begin
                            rd_en      = in_rng;
                            rd_addr    = map_addr;
                            idx_next   = map_addr;
                            wrow_next  = ny[ROW_W-1:0];
                            wok_next   = in_rng;
                            color_next = req.pixel_color;
                            state_next = S_WRITE;
                        end
                        MODE_FILL:
                        begin
                            color_next   = req.pixel_color;
                            sweep_next   = '0;
                            state_next   = S_FILL;
                        end
                        MODE_START:
                        begin
                            if (active_reg)
                            begin
                                rescan_next = 1'b1;
                            end
                            else
                            begin
                                active_next   = 1'b1;
                                rescan_next   = 1'b0;
                                scan_row_next = '0;
                                region_next   = 1'b0;
                                wsent_next    = 1'b0;
                            end
                        end
                        MODE_PULL:
                        begin
                            if (!active_reg)
                            begin
                                stage_next = '0;
                                state_next = S_EMIT;
                            end
                            else if (!region_reg)
                            begin
                                probe_next = scan_row_reg;
                                run_next   = 1'b0;
                                state_next = S_SEEK;
                            end
                            else if (!wsent_reg)
                            begin
                                wsent_next = 1'b1;
                                chunk_next = '0;
                                stage_next = win_res;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cur_addr;
                                idx_next   = cur_addr;
                                state_next = S_PIXEL;
                            end
                        end
                    endcase
                end
            end

            S_WRITE:
            begin
                if (wok_reg && (f_rdata != color_reg))
                begin
                    f_we    = 1'b1;
                    wr_addr = idx_reg;
                    t_we    = 1'b1;
                    t_waddr = wrow_reg;
                    t_wdata = 1'b1;
                end
                state_next = S_IDLE;
            end

            S_FILL:
            begin
                f_we    = 1'b1;
                t_we    = (sweep_reg < H_A);
                t_wdata = 1'b1;
                if (sweep_reg == LAST_A)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end

            S_SEEK:
            begin
                if (probe_reg >= H_P)
                begin
                    if (run_reg)
                    begin
                        region_next   = 1'b1;
                        wsent_next    = 1'b1;
                        chunk_next    = '0;
                        cx_next       = x0_reg;
                        cy_next       = y0_reg;
                        scan_row_next = probe_reg;
                        stage_next    = win_res;
                        state_next    = S_EMIT;
                    end
                    else if (rescan_reg)
                    begin
                        rescan_next = 1'b0;
                        probe_next  = '0;
                    end
                    else
                    begin
                        active_next   = 1'b0;
                        scan_row_next = probe_reg;
                        stage_next    = '0;
                        state_next    = S_EMIT;
                    end
                end
                else if (!t_rdata)
                begin
                    if (run_reg)
                    begin
                        region_next   = 1'b1;
                        wsent_next    = 1'b1;
                        chunk_next    = '0;
                        cx_next       = x0_reg;
                        cy_next       = y0_reg;
                        scan_row_next = probe_reg;
                        stage_next    = win_res;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        probe_next = probe_reg + PROBE_W'(1);
                    end
                end
                else
                begin
                    span_ctrl.clear = 1'b1;
                    col_next        = '0;
                    issued_next     = 1'b0;
                    state_next      = S_COLS;
                end
            end

            S_COLS:
            begin
                if (!issued_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = row_addr;
                    cmp_v_next   = 1'b1;
                    cmp_col_next = col_reg;
                    if (col_reg == LAST_COL)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + COORD_W'(1);
                    end
                end
                if (cmp_v_reg && (cmp_col_reg == LAST_COL))
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (span_stat.any)
                begin
                    if (!run_reg)
                    begin
                        x0_next  = span_stat.lo;
                        x1_next  = span_stat.hi;
                        y0_next  = COORD_W'(probe_reg);
                        run_next = 1'b1;
                    end
                    else
                    begin
                        if (span_stat.lo < x0_reg)
                        begin
                            x0_next = span_stat.lo;
                        end
                        if (span_stat.hi > x1_reg)
                        begin
                            x1_next = span_stat.hi;
                        end
                    end
                    y1_next    = COORD_W'(probe_reg);
                    probe_next = probe_reg + PROBE_W'(1);
                    state_next = S_SEEK;
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = probe_reg[ROW_W-1:0];
                    t_wdata = 1'b0;
                    if (run_reg)
                    begin
                        region_next   = 1'b1;
                        wsent_next    = 1'b1;
                        chunk_next    = '0;
                        cx_next       = x0_reg;
                        cy_next       = y0_reg;
                        scan_row_next = probe_reg;
                        stage_next    = win_res;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        probe_next = probe_reg + PROBE_W'(1);
                        state_next = S_SEEK;
                    end
                end
            end

            S_PIXEL:
            begin
                s_we       = 1'b1;
                wr_addr    = idx_reg;
                stage_next = '{kind: KIND_PIXEL, win_x_start: '0, win_x_end: '0,
                               win_y_start: '0, win_y_end: '0,
                               pixel_value: f_rdata,
                               chunk_end: last_px || (chunk_inc >= CHUNK_C)};
                if (last_px || (chunk_inc >= CHUNK_C))
                begin
                    chunk_next = '0;
                end
                else
                begin
                    chunk_next = chunk_inc;
                end
                if (cx_reg == x1_reg)
                begin
                    cx_next = x0_reg;
                    cy_next = cy_reg + COORD_W'(1);
                end
                else
                begin
                    cx_next = cx_reg + COORD_W'(1);
                end
                if (last_px)
                begin
                    region_next = 1'b0;
                    wsent_next  = 1'b0;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_next       = stage_reg;
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.kind        = out_reg.kind;
    assign res.win_x_start = out_reg.win_x_start;
    assign res.win_x_end   = out_reg.win_x_end;
    assign res.win_y_start = out_reg.win_y_start;
    assign res.win_y_end   = out_reg.win_y_end;
    assign res.pixel_value = out_reg.pixel_value;
    assign res.chunk_end   = out_reg.chunk_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rotation_reg  <= 2'd0;
            sweep_reg     <= '0;
            wok_reg       <= 1'b0;
            scan_row_reg  <= '0;
            probe_reg     <= '0;
            run_reg       <= 1'b0;
            active_reg    <= 1'b0;
            rescan_reg    <= 1'b0;
            region_reg    <= 1'b0;
            wsent_reg     <= 1'b0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            y0_reg        <= '0;
            y1_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            chunk_reg     <= '0;
            col_reg       <= '0;
            issued_reg    <= 1'b0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rotation_reg  <= rotation_next;
            sweep_reg     <= sweep_next;
            wok_reg       <= wok_next;
            scan_row_reg  <= scan_row_next;
            probe_reg     <= probe_next;
            run_reg       <= run_next;
            active_reg    <= active_next;
            rescan_reg    <= rescan_next;
            region_reg    <= region_next;
            wsent_reg     <= wsent_next;
            x0_reg        <= x0_next;
            x1_reg        <= x1_next;
            y0_reg        <= y0_next;
            y1_reg        <= y1_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            chunk_reg     <= chunk_next;
            col_reg       <= col_next;
            issued_reg    <= issued_next;
            cmp_v_reg     <= cmp_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        wrow_reg    <= wrow_next;
        color_reg   <= color_next;
        cmp_col_reg <= cmp_col_next;
        stage_reg   <= stage_next;
        out_reg     <= out_next;
    end

endmodule

FILE: test/tb_dirty_region_frame_updater.sv
`timescale 1ns / 1ps
// Testbench of the dirty region frame updater: random and directed requests, self-checked.
module tb_dirty_region_frame_updater;
    import dru_pkg::*;

    localparam int W         = DEF_PANEL_WIDTH;
    localparam int H         = DEF_PANEL_HEIGHT;
    localparam int CHUNK     = DEF_CHUNK_PIXELS;
    localparam int NPIX      = W * H;
    localparam int MAX_CYC   = 3000000;
    localparam int PHASE_REQ = 300;

    typedef struct {
        mode_t       mode;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] c;
    } req_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dru_req_if req_ch ();
    dru_res_if res_ch ();

    dirty_region_frame_updater i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model of the block
    logic [15:0] frame_px [NPIX];
    logic [15:0] shadow_px [NPIX];
    bit          row_dirty [H];
    logic [1:0]  rot;
    int          scan_at;
    bit          busy;
    bit          rescan;
    bit          in_region;
    bit          window_out;
    int          bx0, bx1, by0, by1;
    int          cur_col, cur_row;
    int          chunk_n;

    req_item_t pending_q [$];
    res_t      results_q [$];
    int        errors;
    int        cycles;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("dirty_region_frame_updater: mismatch");
            $finish;
        end
    end

    function automatic bit row_span(int y, output int a, output int b);
        int base, lo, hi;
        if (y >= H || !row_dirty[y])
            return 0;
        base = y * W;
        lo = 0;
        while (lo < W && frame_px[base + lo] == shadow_px[base + lo])
            lo++;
        if (lo == W)
        begin
            row_dirty[y] = 0;
            return 0;
        end
        hi = W - 1;
        while (hi > lo && frame_px[base + hi] == shadow_px[base + hi])
            hi--;
        a = lo;
        b = hi;
        return 1;
    endfunction

    function automatic bit seek_region();
        int x0, x1, a, b, y1;
        for (int pass = 0; pass < 2; pass++)
        begin
            while (scan_at < H)
            begin
                if (row_span(scan_at, x0, x1))
                begin
                    y1 = scan_at;
                    while (y1 + 1 < H && row_span(y1 + 1, a, b))
                    begin
                        if (a < x0) x0 = a;
                        if (b > x1) x1 = b;
                        y1++;
                    end
                    bx0 = x0;
                    bx1 = x1;
                    by0 = scan_at;
                    by1 = y1;
                    cur_col = 0;
                    cur_row = scan_at;
                    in_region = 1;
                    window_out = 0;
                    scan_at = y1 + 1;
                    return 1;
                end
                scan_at++;
            end
            if (!rescan)
                return 0;
            rescan = 0;
            scan_at = 0;
        end
        return 0;
    endfunction

    task automatic apply_request(req_item_t it);
        int nx, ny, idx, w;
        bit last;
        res_t r;
        r = '0;
        case (it.mode)
            MODE_WRITE:
            begin
                case (rot)
                    2'd1:    begin nx = W - 1 - it.y; ny = it.x;         end
                    2'd2:    begin nx = W - 1 - it.x; ny = H - 1 - it.y; end
                    2'd3:    begin nx = it.y;         ny = H - 1 - it.x; end
                    default: begin nx = it.x;         ny = it.y;         end
                endcase
                if (nx >= 0 && nx < W && ny >= 0 && ny < H)
                begin
                    idx = ny * W + nx;
                    if (frame_px[idx] != it.c)
                    begin
                        frame_px[idx] = it.c;
                        row_dirty[ny] = 1;
                    end
                end
            end
            MODE_FILL:
            begin
                for (int i = 0; i < NPIX; i++)
                    frame_px[i] = it.c;
                for (int i = 0; i < H; i++)
                    row_dirty[i] = 1;
            end
            MODE_START:
            begin
                if (busy)
                    rescan = 1;
                else
                begin
                    busy = 1;
                    rescan = 0;
                    scan_at = 0;
                    in_region = 0;
                    window_out = 0;
                end
            end
            default:
            begin
                r.kind = KIND_IDLE;
                if (busy)
                begin
                    if (!in_region && !seek_region())
                        busy = 0;
                    else if (!window_out)
                    begin
                        window_out = 1;
                        chunk_n = 0;
                        r.kind = KIND_WINDOW;
                        r.win_x_start = bx0[7:0];
                        r.win_x_end = bx1[7:0];
                        r.win_y_start = by0[7:0];
                        r.win_y_end = by1[7:0];
                    end
                    else
                    begin
                        w = bx1 - bx0 + 1;
                        idx = cur_row * W + bx0 + cur_col;
                        last = 0;
                        if (idx >= NPIX)
                        begin
                            in_region = 0;
                            chunk_n = 0;
                        end
                        else
                        begin
                            shadow_px[idx] = frame_px[idx];
                            r.kind = KIND_PIXEL;
                            r.pixel_value = frame_px[idx];
                            chunk_n++;
                            cur_col++;
                            if (cur_col >= w)
                            begin
                                cur_col = 0;
                                cur_row++;
                                if (cur_row > by1)
                                begin
                                    in_region = 0;
                                    window_out = 0;
                                    last = 1;
                                end
                            end
                            if (last || chunk_n >= CHUNK)
                            begin
                                r.chunk_end = 1'b1;
                                chunk_n = 0;
                            end
                        end
                    end
                end
                results_q.push_back(r);
            end
        endcase
    endtask

    // request driver: bursts with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        req_item_t it;
        bit go;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.mode <= MODE_WRITE;
            req_ch.pos_x <= '0;
            req_ch.pos_y <= '0;
            req_ch.pixel_color <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
            begin
                it.mode = mode_t'(req_ch.mode);
                it.x = req_ch.pos_x;
                it.y = req_ch.pos_y;
                it.c = req_ch.pixel_color;
                apply_request(it);
            end
            go = 0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_q.size() > 0)
            begin
                it = pending_q.pop_front();
                req_ch.mode <= it.mode;
                req_ch.pos_x <= it.x;
                req_ch.pos_y <= it.y;
                req_ch.pixel_color <= it.c;
                go = 1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            req_ch.valid <= go;
        end
    end

    // result sink: stall styles plus an occasional long hold
    int taken;
    int hold_left;
    int style;
    int style_left;

    always @(posedge clk or negedge rst_n)
    begin
        bit rdy;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            taken = 0;
            hold_left = 0;
            style = 0;
            style_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                taken++;
                if (taken % 200 == 100)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = $urandom_range(0, 2);
                    style_left = $urandom_range(16, 128);
                end
                style_left--;
                case (style)
                    0:       rdy = 1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.kind = kind_t'(res_ch.kind);
            got.win_x_start = res_ch.win_x_start;
            got.win_x_end = res_ch.win_x_end;
            got.win_y_start = res_ch.win_y_start;
            got.win_y_end = res_ch.win_y_end;
            got.pixel_value = res_ch.pixel_value;
            got.chunk_end = res_ch.chunk_end;
            if (results_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = results_q.pop_front();
                if (got.kind !== want.kind || got.win_x_start !== want.win_x_start
                    || got.win_x_end !== want.win_x_end
                    || got.win_y_start !== want.win_y_start
                    || got.win_y_end !== want.win_y_end
                    || got.pixel_value !== want.pixel_value
                    || got.chunk_end !== want.chunk_end)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result differs: expected %p got %p", want, got);
                end
            end
        end
    end

    task automatic queue_req(mode_t m, int x, int y, int c);
        req_item_t it;
        it.mode = m;
        it.x = x[7:0];
        it.y = y[7:0];
        it.c = c[15:0];
        pending_q.push_back(it);
    endtask

    task automatic write_rotation(logic [1:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_ROTATION);
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rot = v;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !req_ch.valid && results_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic int pick_color();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 16'hffff;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic random_phase(int amount);
        int n, bx, by, k;
        n = 0;
        while (n < amount)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: loose requests, never a fill
                k = $urandom_range(0, 3);
                queue_req(k == MODE_FILL ? MODE_START : mode_t'(k), $urandom_range(0, 255),
                          $urandom_range(0, 255), pick_color());
                n++;
            end
            else
            begin
                bx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 134);
                by = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 134);
                k = $urandom_range(1, 10);
                for (int i = 0; i < k; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        queue_req(MODE_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                                  pick_color());
                    else
                        queue_req(MODE_WRITE, bx + $urandom_range(0, 5), by + $urandom_range(0, 3),
                                  pick_color());
                end
                queue_req(MODE_START, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 65535));
                n += k + 1;
                k = $urandom_range(1, 40);
                for (int i = 0; i < k; i++)
                begin
                    if ($urandom_range(0, 29) == 0)
                        queue_req(MODE_START, 0, 0, 0);
                    else
                        queue_req(MODE_PULL, $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 65535));
                end
                n += k;
            end
        end
        queue_req(MODE_PULL, 0, 0, 0);
    endtask

    initial
    begin
        logic [1:0] rot_seq [4];
        rot_seq = '{2'd3, 2'd1, 2'd2, 2'd0};
        for (int i = 0; i < NPIX; i++)
        begin
            frame_px[i] = '0;
            shadow_px[i] = '0;
        end
        for (int i = 0; i < H; i++)
            row_dirty[i] = 0;
        rot = '0;
        scan_at = 0;
        busy = 0;
        rescan = 0;
        in_region = 0;
        window_out = 0;
        bx0 = 0; bx1 = 0; by0 = 0; by1 = 0;
        cur_col = 0; cur_row = 0;
        chunk_n = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        queue_req(MODE_WRITE, 0, 0, 16'hffff);
        queue_req(MODE_WRITE, 134, 239, 16'h8000);
        queue_req(MODE_WRITE, 134, 239, 16'h8000);
        queue_req(MODE_WRITE, 134, 0, 0);
        queue_req(MODE_WRITE, 255, 255, 1);
        queue_req(MODE_WRITE, 135, 0, 2);
        queue_req(MODE_PULL, 0, 0, 0);
        queue_req(MODE_START, 0, 0, 0);
        queue_req(MODE_PULL, 0, 0, 0);
        queue_req(MODE_PULL, 0, 0, 0);
        queue_req(MODE_START, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            queue_req(MODE_PULL, 0, 0, 0);
        queue_req(MODE_FILL, 255, 255, 16'h1234);
        queue_req(MODE_FILL, 0, 0, 0);
        queue_req(MODE_START, 0, 0, 0);
        queue_req(MODE_PULL, 0, 0, 0);
        queue_req(MODE_PULL, 0, 0, 0);
        drain();

        foreach (rot_seq[p])
        begin
            write_rotation(rot_seq[p]);
            random_phase(PHASE_REQ);
            drain();
        end

        if (errors == 0)
            $display("dirty_region_frame_updater: match");
        else
            $display("dirty_region_frame_updater: mismatch");
        $finish;
    end

endmodule

FILE: dirty_region_frame_updater.f
hdl/dru_pkg.sv
hdl/dru_req_if.sv
hdl/dru_res_if.sv
hdl/dru_ram.sv
hdl/dru_span.sv
hdl/dirty_region_frame_updater.sv
test/tb_dirty_region_frame_updater.sv
